// ===== design/vfc_pkg.sv =====
`default_nettype none

package vfc_pkg;

  localparam int CoordW   = 4;
  localparam int HalfW    = 4;
  localparam int KindW    = 3;
  localparam int SideW    = 3;
  localparam int TileW    = 8;
  localparam int RegW     = 40;
  localparam int CfgIdxW  = 1;
  localparam int NumSides = 6;
  localparam int InDataW  = 24;
  localparam int OutDataW = 40;

  localparam logic [1:0] OP_WR_VOXEL = 2'd0;
  localparam logic [1:0] OP_WR_PLANE = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  localparam logic [SideW-1:0] SIDE_TOP      = 3'd0;
  localparam logic [SideW-1:0] SIDE_BOTTOM   = 3'd1;
  localparam logic [SideW-1:0] SIDE_LEFT     = 3'd2;
  localparam logic [SideW-1:0] SIDE_RIGHT    = 3'd3;
  localparam logic [SideW-1:0] SIDE_FORWARD  = 3'd4;
  localparam logic [SideW-1:0] SIDE_BACKWARD = 3'd5;

  localparam logic [KindW-1:0] KIND_AIR = 3'd0;
  localparam logic [KindW-1:0] KIND_MAX = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_TILE_COL = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_TILE_ROW = 1'b1;

  typedef enum logic [1:0] {
    CMD_WR_VOXEL,
    CMD_WR_PLANE,
    CMD_QUERY
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                 op;
    logic [CoordW-1:0]       x;
    logic [CoordW-1:0]       y;
    logic [CoordW-1:0]       z;
    logic [KindW-1:0]        kind;
    logic [SideW-1:0]        side;
    logic                    solid;
    logic [NumSides-1:0]     at_edge;
    logic [HalfW-1:0]        xm;
    logic [HalfW-1:0]        xp;
    logic [HalfW-1:0]        ym;
    logic [HalfW-1:0]        yp;
    logic [HalfW-1:0]        zm;
    logic [HalfW-1:0]        zp;
  } cmd_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [SideW-1:0]  dir;
    logic [KindW-1:0]  kind;
    logic [TileW-1:0]  col;
    logic [TileW-1:0]  row;
    logic              last;
  } face_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDB,
    ST_EVAL,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/vfc_front.sv =====
`default_nettype none

module vfc_front #(
  parameter int EDGE_SIZE = 16
) (
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [vfc_pkg::InDataW-1:0]   in_tdata,
  input  wire [1:0]                    in_tuser,
  input  wire                          q_full,
  input  wire                          clearing,
  output logic                         push,
  output vfc_pkg::cmd_t                cmd
);

  logic [vfc_pkg::CoordW-1:0] px, py, pz;
  logic [vfc_pkg::KindW-1:0]  kind;
  logic [vfc_pkg::SideW-1:0]  side;
  logic                       solid;
  logic                       x_ok, y_ok, z_ok, plane_ok, cmd_ok;

  assign px    = in_tdata[3:0];
  assign py    = in_tdata[7:4];
  assign pz    = in_tdata[11:8];
  assign kind  = in_tdata[14:12];
  assign side  = in_tdata[17:15];
  assign solid = in_tdata[18];

  assign x_ok = 32'(px) < EDGE_SIZE;
  assign y_ok = 32'(py) < EDGE_SIZE;
  assign z_ok = 32'(pz) < EDGE_SIZE;

  // boundary writes only check the two coordinates that index the plane
  always_comb begin
    unique case (side) inside
      vfc_pkg::SIDE_TOP, vfc_pkg::SIDE_BOTTOM:       plane_ok = x_ok && z_ok;
      vfc_pkg::SIDE_LEFT, vfc_pkg::SIDE_RIGHT:       plane_ok = y_ok && z_ok;
      vfc_pkg::SIDE_FORWARD, vfc_pkg::SIDE_BACKWARD: plane_ok = x_ok && y_ok;
      default:                                       plane_ok = 1'b0;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.op    = vfc_pkg::CMD_QUERY;
    cmd.x     = px;
    cmd.y     = py;
    cmd.z     = pz;
    cmd.kind  = kind;
    cmd.side  = side;
    cmd.solid = solid;
    cmd.at_edge[vfc_pkg::SIDE_TOP]      = 32'(py) == EDGE_SIZE - 1;
    cmd.at_edge[vfc_pkg::SIDE_BOTTOM]   = py == '0;
    cmd.at_edge[vfc_pkg::SIDE_LEFT]     = px == '0;
    cmd.at_edge[vfc_pkg::SIDE_RIGHT]    = 32'(px) == EDGE_SIZE - 1;
    cmd.at_edge[vfc_pkg::SIDE_FORWARD]  = 32'(pz) == EDGE_SIZE - 1;
    cmd.at_edge[vfc_pkg::SIDE_BACKWARD] = pz == '0;
    // half coordinates of the neighbors, i.e. their address inside a parity bank
    cmd.xm = vfc_pkg::HalfW'((5'(px) - 5'd1) >> 1);
    cmd.xp = vfc_pkg::HalfW'((5'(px) + 5'd1) >> 1);
    cmd.ym = vfc_pkg::HalfW'((5'(py) - 5'd1) >> 1);
    cmd.yp = vfc_pkg::HalfW'((5'(py) + 5'd1) >> 1);
    cmd.zm = vfc_pkg::HalfW'((5'(pz) - 5'd1) >> 1);
    cmd.zp = vfc_pkg::HalfW'((5'(pz) + 5'd1) >> 1);
    cmd_ok = 1'b0;
    unique case (in_tuser)
      vfc_pkg::OP_WR_VOXEL: begin
        cmd.op = vfc_pkg::CMD_WR_VOXEL;
        cmd_ok = x_ok && y_ok && z_ok && (kind <= vfc_pkg::KIND_MAX);
      end
      vfc_pkg::OP_WR_PLANE: begin
        cmd.op = vfc_pkg::CMD_WR_PLANE;
        cmd_ok = plane_ok;
      end
      vfc_pkg::OP_QUERY: begin
        cmd.op = vfc_pkg::CMD_QUERY;
        cmd_ok = x_ok && y_ok && z_ok;
      end
      default: cmd_ok = 1'b0;
    endcase
  end

  assign in_tready = !q_full && !clearing;
  // items that do nothing are taken and dropped here
  assign push      = in_tvalid && in_tready && cmd_ok;

endmodule

`default_nettype wire

// ===== design/vfc_cmd_fifo.sv =====
`default_nettype none

module vfc_cmd_fifo (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  vfc_pkg::cmd_t  push_cmd,
  output logic           full,
  input  wire            pop,
  output logic           head_valid,
  output vfc_pkg::cmd_t  head_cmd
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  vfc_pkg::cmd_t   slot [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr_r] <= push_cmd;
    end
  end

  assign full       = count_r == (PtrW + 1)'(Depth);
  assign head_valid = count_r != '0;
  assign head_cmd   = slot[rd_ptr_r];

endmodule

`default_nettype wire

// ===== design/vfc_back.sv =====
`default_nettype none

module vfc_back #(
  parameter int EDGE_SIZE = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            q_valid,
  input  vfc_pkg::cmd_t                  q_cmd,
  output logic                           pop,
  output logic                           clearing,
  input  wire                            cfg_we,
  input  wire [vfc_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire [vfc_pkg::RegW-1:0]        cfg_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output vfc_pkg::face_t                 out_face
);

  localparam int CW         = $clog2(EDGE_SIZE);
  localparam int HW         = (CW > 1) ? CW - 1 : 1;
  localparam int BAW        = 3 * HW;
  localparam int PAW        = 2 * CW;
  localparam int CLW        = (BAW > PAW) ? BAW : PAW;
  localparam int BankDepth  = 2 ** BAW;
  localparam int PlaneDepth = 2 ** PAW;
  localparam int NumBanks   = 8;
  localparam logic [2:0] FLIP_X = 3'b100;
  localparam logic [2:0] FLIP_Y = 3'b010;
  localparam logic [2:0] FLIP_Z = 3'b001;

  localparam int NS = vfc_pkg::NumSides;
  localparam int KW = vfc_pkg::KindW;

  vfc_pkg::back_state_t state_r, state_nxt;
  logic [CLW-1:0]       clr_cnt_r, clr_cnt_nxt;
  vfc_pkg::cmd_t        cmd_r;
  vfc_pkg::cmd_t        cur;
  logic [KW-1:0]        kind_r;
  logic [NS-1:0]        solid_lo_r;
  logic [NS-1:0]        mask_r, mask_nxt;
  logic [vfc_pkg::TileW-1:0] col_r, row_r;
  logic [vfc_pkg::RegW-1:0]  tile_col_r, tile_row_r;
  logic                 out_valid_r, out_valid_nxt;
  vfc_pkg::face_t       out_r;

  logic [2:0]           cb;
  logic                 phase_b;
  logic [HW-1:0]        hx, hy, hz, hxn, hyn, hzn;
  logic [CW-1:0]        cx, cy, cz;
  logic [BAW-1:0]       rd_addr [NumBanks];
  logic [BAW-1:0]       bk_waddr;
  logic [KW-1:0]        bk_wdata;
  logic [NumBanks-1:0]  bk_we;
  logic                 bk_re;
  wire  [KW-1:0]        bk_rdata [NumBanks];
  logic [NS-1:0]        pl_we;
  logic                 pl_re;
  logic                 pl_wdata;
  wire  [NS-1:0]        pl_rdata;
  logic [NS-1:0]        solid_lo, solid_all, vis;
  logic                 kind_ok;
  logic [vfc_pkg::SideW-1:0] pick;
  logic [NS-1:0]        rest;
  logic                 load_face;

  assign cur     = (state_r == vfc_pkg::ST_IDLE) ? q_cmd : cmd_r;
  assign phase_b = state_r == vfc_pkg::ST_RDB;
  assign cb      = {cur.x[0], cur.y[0], cur.z[0]};
  assign hx      = HW'(cur.x >> 1);
  assign hy      = HW'(cur.y >> 1);
  assign hz      = HW'(cur.z >> 1);
  assign hxn     = phase_b ? HW'(cur.xp) : HW'(cur.xm);
  assign hyn     = phase_b ? HW'(cur.yp) : HW'(cur.ym);
  assign hzn     = phase_b ? HW'(cur.zp) : HW'(cur.zm);
  assign cx      = CW'(cur.x);
  assign cy      = CW'(cur.y);
  assign cz      = CW'(cur.z);

  // neighbors along an axis sit in the bank with that parity bit flipped
  always_comb begin
    for (int i = 0; i < NumBanks; i++) begin
      if (3'(i) == (cb ^ FLIP_X)) begin
        rd_addr[i] = {hxn, hy, hz};
      end else if (3'(i) == (cb ^ FLIP_Y)) begin
        rd_addr[i] = {hx, hyn, hz};
      end else if (3'(i) == (cb ^ FLIP_Z)) begin
        rd_addr[i] = {hx, hy, hzn};
      end else begin
        rd_addr[i] = {hx, hy, hz};
      end
    end
  end

  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    logic [KW-1:0] mem [BankDepth];
    logic [KW-1:0] rdata_q;
    always_ff @(posedge clk) begin
      if (bk_we[b]) begin
        mem[bk_waddr] <= bk_wdata;
      end
      if (bk_re) begin
        rdata_q <= mem[rd_addr[b]];
      end
    end
    assign bk_rdata[b] = rdata_q;
  end

  for (genvar s = 0; s < NS; s++) begin : g_plane
    logic           mem [PlaneDepth];
    logic           rdata_q;
    logic [PAW-1:0] addr;
    logic [PAW-1:0] waddr;
    if (s < 2) begin : g_xz
      assign addr = {cx, cz};
    end else if (s < 4) begin : g_yz
      assign addr = {cy, cz};
    end else begin : g_xy
      assign addr = {cx, cy};
    end
    assign waddr = (state_r == vfc_pkg::ST_CLEAR) ? clr_cnt_r[PAW-1:0] : addr;
    always_ff @(posedge clk) begin
      if (pl_we[s]) begin
        mem[waddr] <= pl_wdata;
      end
      if (pl_re) begin
        rdata_q <= mem[addr];
      end
    end
    assign pl_rdata[s] = rdata_q;
  end

  // first read phase: center and the three minus neighbors
  always_comb begin
    solid_lo = '0;
    solid_lo[vfc_pkg::SIDE_BOTTOM] = cur.at_edge[vfc_pkg::SIDE_BOTTOM] ?
        pl_rdata[vfc_pkg::SIDE_BOTTOM] : (bk_rdata[cb ^ FLIP_Y] != vfc_pkg::KIND_AIR);
    solid_lo[vfc_pkg::SIDE_LEFT] = cur.at_edge[vfc_pkg::SIDE_LEFT] ?
        pl_rdata[vfc_pkg::SIDE_LEFT] : (bk_rdata[cb ^ FLIP_X] != vfc_pkg::KIND_AIR);
    solid_lo[vfc_pkg::SIDE_BACKWARD] = cur.at_edge[vfc_pkg::SIDE_BACKWARD] ?
        pl_rdata[vfc_pkg::SIDE_BACKWARD] : (bk_rdata[cb ^ FLIP_Z] != vfc_pkg::KIND_AIR);
  end

  // second read phase: the plus neighbors
  always_comb begin
    solid_all = solid_lo_r;
    solid_all[vfc_pkg::SIDE_TOP] = cur.at_edge[vfc_pkg::SIDE_TOP] ?
        pl_rdata[vfc_pkg::SIDE_TOP] : (bk_rdata[cb ^ FLIP_Y] != vfc_pkg::KIND_AIR);
    solid_all[vfc_pkg::SIDE_RIGHT] = cur.at_edge[vfc_pkg::SIDE_RIGHT] ?
        pl_rdata[vfc_pkg::SIDE_RIGHT] : (bk_rdata[cb ^ FLIP_X] != vfc_pkg::KIND_AIR);
    solid_all[vfc_pkg::SIDE_FORWARD] = cur.at_edge[vfc_pkg::SIDE_FORWARD] ?
        pl_rdata[vfc_pkg::SIDE_FORWARD] : (bk_rdata[cb ^ FLIP_Z] != vfc_pkg::KIND_AIR);
  end

  assign vis     = ~solid_all;
  assign kind_ok = (kind_r != vfc_pkg::KIND_AIR) && (kind_r <= vfc_pkg::KIND_MAX);

  always_comb begin
    pick = '0;
    for (int s = NS - 1; s >= 0; s--) begin
      if (mask_r[s]) begin
        pick = vfc_pkg::SideW'(s);
      end
    end
  end

  assign rest = mask_r & ~(NS'(1) << pick);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vfc_pkg::ST_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = vfc_pkg::ST_IDLE;
        end
      end
      vfc_pkg::ST_IDLE: begin
        if (q_valid && q_cmd.op == vfc_pkg::CMD_QUERY) begin
          state_nxt = vfc_pkg::ST_RDB;
        end
      end
      vfc_pkg::ST_RDB: state_nxt = vfc_pkg::ST_EVAL;
      vfc_pkg::ST_EVAL: begin
        if (kind_ok && vis != '0) begin
          state_nxt = vfc_pkg::ST_EMIT;
        end else begin
          state_nxt = vfc_pkg::ST_IDLE;
        end
      end
      vfc_pkg::ST_EMIT: begin
        if (load_face && rest == '0) begin
          state_nxt = vfc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vfc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    bk_re     = 1'b0;
    pl_re     = 1'b0;
    bk_we     = '0;
    pl_we     = '0;
    bk_waddr  = {hx, hy, hz};
    bk_wdata  = cur.kind;
    pl_wdata  = cur.solid;
    load_face = 1'b0;
    unique case (state_r)
      vfc_pkg::ST_CLEAR: begin
        bk_we    = '1;
        pl_we    = '1;
        bk_waddr = clr_cnt_r[BAW-1:0];
        bk_wdata = vfc_pkg::KIND_AIR;
        pl_wdata = 1'b0;
      end
      vfc_pkg::ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          unique case (q_cmd.op)
            vfc_pkg::CMD_WR_VOXEL: bk_we[cb] = 1'b1;
            vfc_pkg::CMD_WR_PLANE: pl_we[q_cmd.side] = 1'b1;
            vfc_pkg::CMD_QUERY: begin
              bk_re = 1'b1;
              pl_re = 1'b1;
            end
            default: ;
          endcase
        end
      end
      vfc_pkg::ST_RDB:  bk_re = 1'b1;
      vfc_pkg::ST_EVAL: ;
      vfc_pkg::ST_EMIT: load_face = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    clr_cnt_nxt = (state_r == vfc_pkg::ST_CLEAR) ? clr_cnt_r + 1'b1 : clr_cnt_r;
    mask_nxt    = mask_r;
    if (state_r == vfc_pkg::ST_EVAL) begin
      mask_nxt = vis;
    end else if (load_face) begin
      mask_nxt = rest;
    end
    if (load_face) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vfc_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      tile_col_r  <= '0;
      tile_row_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          vfc_pkg::REG_TILE_COL: tile_col_r <= cfg_data;
          vfc_pkg::REG_TILE_ROW: tile_row_r <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == vfc_pkg::ST_IDLE && pop) begin
      cmd_r <= q_cmd;
    end
    if (state_r == vfc_pkg::ST_RDB) begin
      kind_r     <= bk_rdata[cb];
      solid_lo_r <= solid_lo;
    end
    if (state_r == vfc_pkg::ST_EVAL) begin
      col_r <= vfc_pkg::TileW'(tile_col_r >> {kind_r - 3'd1, 3'b000});
      row_r <= vfc_pkg::TileW'(tile_row_r >> {kind_r - 3'd1, 3'b000});
    end
    if (load_face) begin
      out_r.x    <= cmd_r.x;
      out_r.y    <= cmd_r.y;
      out_r.z    <= cmd_r.z;
      out_r.dir  <= pick;
      out_r.kind <= kind_r;
      out_r.col  <= col_r;
      out_r.row  <= row_r;
      out_r.last <= rest == '0;
    end
  end

  assign clearing  = state_r == vfc_pkg::ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_face  = out_r;

endmodule

`default_nettype wire

// ===== design/voxel_face_culler.sv =====
// channel | dir | tdata fields, lowest bit first              | side band
// in_     | in  | pos_x, pos_y, pos_z, kind, side, solid       | tuser: operation
// out_    | out | face_x, face_y, face_z, face_dir, face_kind, | tlast: last
//         |     | tile_col, tile_row                           |
// cfg_    | in  | index 0 tile_column_table, 1 tile_row_table | write only
//
// In the back end a write is done in the IDLE state; a query reads the eight parity
// banks of the voxel grid in two read phases (IDLE, then RDB), EVAL decides which faces
// show, and EMIT sends one face record at a time as out_tready allows. After reset a
// clearing pass over every bank and plane address holds in_tready low.
// A two-entry command queue lets the input side keep going while records wait on out_tready.
`default_nettype none

module voxel_face_culler #(
  parameter int EDGE_SIZE = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  input  wire [vfc_pkg::InDataW-1:0]    in_tdata,   // pos_x, pos_y, pos_z, kind, side, solid
  input  wire [1:0]                     in_tuser,   // operation
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [vfc_pkg::OutDataW-1:0]  out_tdata,  // x, y, z, dir, kind, tile_col, tile_row
  output logic                          out_tlast,
  input  wire                           cfg_we,
  input  wire [vfc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire [vfc_pkg::RegW-1:0]       cfg_data
);

  logic           push, q_full, q_valid, pop, clearing;
  vfc_pkg::cmd_t  push_cmd, q_cmd;
  vfc_pkg::face_t face;

  vfc_front #(
    .EDGE_SIZE(EDGE_SIZE)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .cmd       (push_cmd)
  );

  vfc_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  vfc_back #(
    .EDGE_SIZE(EDGE_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .clearing  (clearing),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_face  (face)
  );

  assign out_tdata = vfc_pkg::OutDataW'({face.row, face.col, face.kind, face.dir,
                                         face.z, face.y, face.x});
  assign out_tlast = face.last;

endmodule

`default_nettype wire

// ===== design/vfc_checker.sv =====
`default_nettype none

module vfc_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_tready,
  input wire                          out_tvalid,
  input wire                          out_tready,
  input wire [vfc_pkg::OutDataW-1:0]  out_tdata,
  input wire                          out_tlast
);

  // stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("face record changed while stalled");

  // grid is being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready)
    else $error("input taken before grid clear");

  // records of one query follow back to back, same voxel, rising side order
  a_burst_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[14:12] > $past(out_tdata[14:12]))
      && (out_tdata[11:0] == $past(out_tdata[11:0]))
      && (out_tdata[17:15] == $past(out_tdata[17:15])))
    else $error("face burst broken");

endmodule

bind voxel_face_culler vfc_checker u_vfc_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int Edge = 16;
  localparam logic [1:0] OpNone = 2'd3;
  localparam int SettleCycles = 32;
  localparam int CycleLimit = 200000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  wire in_tready;
  logic [vfc_pkg::InDataW-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  wire out_tvalid;
  logic out_tready = 1'b0;
  wire [vfc_pkg::OutDataW-1:0] out_tdata;
  wire out_tlast;
  logic cfg_we = 1'b0;
  logic [vfc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [vfc_pkg::RegW-1:0] cfg_data = '0;

  bit [vfc_pkg::KindW-1:0] grid_model [0:Edge*Edge*Edge-1];
  bit plane_model [0:6*Edge*Edge-1];
  logic [vfc_pkg::RegW-1:0] col_table = '0;
  logic [vfc_pkg::RegW-1:0] row_table = '0;
  vfc_pkg::face_t face_q [$];
  vfc_pkg::face_t mon_want, mon_got;
  int errors = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  logic [2:0] corner = '0;

  voxel_face_culler #(.EDGE_SIZE(Edge)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int vox(int x, int y, int z);
    return (x * Edge + y) * Edge + z;
  endfunction

  function automatic int pln(int s, int a, int b);
    return (s * Edge + a) * Edge + b;
  endfunction

  function automatic bit covered(int x, int y, int z, int s);
    case (s)
      vfc_pkg::SIDE_TOP:
        return (y < Edge - 1) ? grid_model[vox(x, y + 1, z)] != 0 : plane_model[pln(s, x, z)];
      vfc_pkg::SIDE_BOTTOM:
        return (y > 0) ? grid_model[vox(x, y - 1, z)] != 0 : plane_model[pln(s, x, z)];
      vfc_pkg::SIDE_LEFT:
        return (x > 0) ? grid_model[vox(x - 1, y, z)] != 0 : plane_model[pln(s, y, z)];
      vfc_pkg::SIDE_RIGHT:
        return (x < Edge - 1) ? grid_model[vox(x + 1, y, z)] != 0 : plane_model[pln(s, y, z)];
      vfc_pkg::SIDE_FORWARD:
        return (z < Edge - 1) ? grid_model[vox(x, y, z + 1)] != 0 : plane_model[pln(s, x, y)];
      default:
        return (z > 0) ? grid_model[vox(x, y, z - 1)] != 0 : plane_model[pln(s, x, y)];
    endcase
  endfunction

  task automatic predict_faces(input logic [1:0] op, input logic [3:0] x, y, z,
                               input logic [2:0] kind, side, input logic solid);
    int a, b, s, n, seen;
    logic [vfc_pkg::KindW-1:0] k;
    bit [vfc_pkg::NumSides-1:0] vis;
    vfc_pkg::face_t rec;
    case (op)
      vfc_pkg::OP_WR_VOXEL: begin
        if (kind <= vfc_pkg::KIND_MAX) grid_model[vox(x, y, z)] = kind;
      end
      vfc_pkg::OP_WR_PLANE: begin
        if (side <= vfc_pkg::SIDE_BACKWARD) begin
          if (side < vfc_pkg::SIDE_LEFT) begin
            a = x;
            b = z;
          end else if (side < vfc_pkg::SIDE_FORWARD) begin
            a = y;
            b = z;
          end else begin
            a = x;
            b = y;
          end
          plane_model[pln(side, a, b)] = solid;
        end
      end
      vfc_pkg::OP_QUERY: begin
        k = grid_model[vox(x, y, z)];
        if (k != vfc_pkg::KIND_AIR && k <= vfc_pkg::KIND_MAX) begin
          for (s = 0; s < vfc_pkg::NumSides; s++) vis[s] = !covered(x, y, z, s);
          n = $countones(vis);
          seen = 0;
          for (s = 0; s < vfc_pkg::NumSides; s++) begin
            if (vis[s]) begin
              seen++;
              rec.x = x;
              rec.y = y;
              rec.z = z;
              rec.dir = s[vfc_pkg::SideW-1:0];
              rec.kind = k;
              rec.col = col_table[8*(k-1) +: 8];
              rec.row = row_table[8*(k-1) +: 8];
              rec.last = (seen == n);
              face_q = {face_q, rec};
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic [3:0] x, y, z,
                           input logic [2:0] kind, side, input logic solid);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {5'b0, solid, side, kind, z, y, x};
    do @(posedge clk); while (!in_tready);
    predict_faces(op, x, y, z, kind, side, solid);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (face_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_tiles(input logic [vfc_pkg::RegW-1:0] cols,
                           input logic [vfc_pkg::RegW-1:0] rows);
    cfg_we <= 1'b1;
    cfg_index <= vfc_pkg::REG_TILE_COL;
    cfg_data <= cols;
    @(posedge clk);
    cfg_index <= vfc_pkg::REG_TILE_ROW;
    cfg_data <= rows;
    @(posedge clk);
    cfg_we <= 1'b0;
    col_table = cols;
    row_table = rows;
  endtask

  function automatic logic [vfc_pkg::RegW-1:0] rand_reg();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[vfc_pkg::RegW-1:0];
  endfunction

  function automatic logic [3:0] pick_coord(bit hi);
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return hi ? 4'(15 - $urandom_range(0, 2)) : 4'($urandom_range(0, 2));
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mon_got.x = out_tdata[3:0];
      mon_got.y = out_tdata[7:4];
      mon_got.z = out_tdata[11:8];
      mon_got.dir = out_tdata[14:12];
      mon_got.kind = out_tdata[17:15];
      mon_got.col = out_tdata[25:18];
      mon_got.row = out_tdata[33:26];
      mon_got.last = out_tlast;
      if (face_q.size() == 0) begin
        errors++;
        $error("unexpected face record at (%0d,%0d,%0d) dir %0d",
               mon_got.x, mon_got.y, mon_got.z, mon_got.dir);
      end else begin
        mon_want = face_q.pop_front();
        check_field("face_x", mon_want.x, mon_got.x);
        check_field("face_y", mon_want.y, mon_got.y);
        check_field("face_z", mon_want.z, mon_got.z);
        check_field("face_dir", mon_want.dir, mon_got.dir);
        check_field("face_kind", mon_want.kind, mon_got.kind);
        check_field("tile_col", mon_want.col, mon_got.col);
        check_field("tile_row", mon_want.row, mon_got.row);
        check_field("last", mon_want.last, mon_got.last);
      end
    end
  end

  // receiver back-pressure in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 9);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic test_empty_grid();
    send_item(vfc_pkg::OP_QUERY, 4'd0, 4'd0, 4'd0, 3'd1, 3'd0, 1'b1);
  endtask

  task automatic test_corner_faces();
    send_item(vfc_pkg::OP_WR_VOXEL, 4'd0, 4'd0, 4'd0, 3'd1, 3'd0, 1'b0);
    send_item(vfc_pkg::OP_QUERY, 4'd0, 4'd0, 4'd0, 3'd0, 3'd0, 1'b0);
    send_item(vfc_pkg::OP_WR_VOXEL, 4'd15, 4'd15, 4'd15, 3'd5, 3'd7, 1'b1);
    send_item(vfc_pkg::OP_QUERY, 4'd15, 4'd15, 4'd15, 3'd7, 3'd7, 1'b1);
    send_item(vfc_pkg::OP_WR_VOXEL, 4'd1, 4'd0, 4'd0, 3'd2, 3'd0, 1'b0);
    send_item(vfc_pkg::OP_QUERY, 4'd0, 4'd0, 4'd0, 3'd0, 3'd0, 1'b0);
    // bury the origin voxel completely
    send_item(vfc_pkg::OP_WR_PLANE, 4'd0, 4'd0, 4'd0, 3'd0, vfc_pkg::SIDE_BOTTOM, 1'b1);
    send_item(vfc_pkg::OP_WR_PLANE, 4'd0, 4'd0, 4'd0, 3'd0, vfc_pkg::SIDE_LEFT, 1'b1);
    send_item(vfc_pkg::OP_WR_PLANE, 4'd0, 4'd0, 4'd0, 3'd0, vfc_pkg::SIDE_BACKWARD, 1'b1);
    send_item(vfc_pkg::OP_WR_VOXEL, 4'd0, 4'd1, 4'd0, 3'd3, 3'd0, 1'b0);
    send_item(vfc_pkg::OP_WR_VOXEL, 4'd0, 4'd0, 4'd1, 3'd4, 3'd0, 1'b0);
    send_item(vfc_pkg::OP_QUERY, 4'd0, 4'd0, 4'd0, 3'd0, 3'd0, 1'b0);
    send_item(vfc_pkg::OP_WR_PLANE, 4'd15, 4'd0, 4'd15, 3'd0, vfc_pkg::SIDE_TOP, 1'b1);
    send_item(vfc_pkg::OP_WR_PLANE, 4'd0, 4'd15, 4'd15, 3'd0, vfc_pkg::SIDE_RIGHT, 1'b1);
    send_item(vfc_pkg::OP_WR_PLANE, 4'd15, 4'd15, 4'd0, 3'd0, vfc_pkg::SIDE_FORWARD, 1'b1);
    send_item(vfc_pkg::OP_QUERY, 4'd15, 4'd15, 4'd15, 3'd0, 3'd0, 1'b0);
    send_item(vfc_pkg::OP_WR_PLANE, 4'd0, 4'd9, 4'd0, 3'd0, vfc_pkg::SIDE_BOTTOM, 1'b0);
    send_item(vfc_pkg::OP_QUERY, 4'd0, 4'd0, 4'd0, 3'd0, 3'd0, 1'b0);
  endtask

  task automatic test_ignored_items();
    send_item(vfc_pkg::OP_WR_VOXEL, 4'd0, 4'd0, 4'd0, 3'd7, 3'd0, 1'b0);
    send_item(vfc_pkg::OP_WR_PLANE, 4'd0, 4'd0, 4'd0, 3'd0, 3'd6, 1'b1);
    send_item(vfc_pkg::OP_QUERY, 4'd0, 4'd0, 4'd0, 3'd0, 3'd0, 1'b0);
    send_item(OpNone, 4'd15, 4'd15, 4'd15, 3'd7, 3'd7, 1'b1);
    send_item(vfc_pkg::OP_WR_VOXEL, 4'd0, 4'd0, 4'd0, vfc_pkg::KIND_AIR, 3'd0, 1'b0);
    send_item(vfc_pkg::OP_QUERY, 4'd0, 4'd0, 4'd0, 3'd0, 3'd0, 1'b0);
  endtask

  task automatic test_tile_extremes();
    wait_idle();
    set_tiles('0, '1);
    send_item(vfc_pkg::OP_QUERY, 4'd15, 4'd15, 4'd15, 3'd0, 3'd0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int i, r;
    logic [1:0] op;
    logic [2:0] kind, side;
    wait_idle();
    set_tiles(rand_reg(), rand_reg());
    for (i = 0; i < 330; i++) begin
      if (i == 110) begin
        wait_idle();
        set_tiles(rand_reg(), rand_reg());
      end
      if (i == 220) begin
        wait_idle();
        set_tiles('1, '1);
      end
      if (i % 40 == 0) corner = 3'($urandom_range(0, 7));
      quiet = (i >= 270);
      r = $urandom_range(0, 99);
      op = (r < 38) ? vfc_pkg::OP_WR_VOXEL :
           (r < 53) ? vfc_pkg::OP_WR_PLANE :
           (r < 96) ? vfc_pkg::OP_QUERY : OpNone;
      r = $urandom_range(0, 9);
      kind = (r == 0) ? 3'($urandom_range(6, 7)) :
             (r < 3) ? vfc_pkg::KIND_AIR : 3'($urandom_range(1, 5));
      side = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_item(op, pick_coord(corner[0]), pick_coord(corner[1]), pick_coord(corner[2]),
                kind, side, 1'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_tiles('1, '0);
    test_empty_grid();
    test_corner_faces();
    test_ignored_items();
    test_tile_extremes();
    test_random_traffic();
    wait_idle();
    if (errors == 0 && face_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
